FILE: design/fpha_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpha_pkg
// Shared types and constants for the fit-policy hole allocator.
// ----------------------------------------------------------------------------
package fpha_pkg;

  // Word field widths
  localparam int CMD_W    = 2;
  localparam int SLOT_W   = 7;
  localparam int AMT_W    = 16;
  localparam int REM_W    = 16;
  localparam int POLICY_W = 2;

  // Configuration port
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Register index of placement_policy (paddr[2])
  localparam logic REG_POLICY = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [POLICY_W-1:0] {
    POL_FIRST = 2'd0,
    POL_NEXT  = 2'd1,
    POL_BEST  = 2'd2,
    POL_WORST = 2'd3
  } policy_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LAST,
    ST_WB,
    ST_RD
  } state_t;

endpackage

FILE: design/fpha_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fpha_chan_if
// Valid/ready channels for the allocator: command words in, result words out.
// ----------------------------------------------------------------------------
interface fpha_in_if import fpha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [SLOT_W-1:0] slot;
  logic [AMT_W-1:0]  amount;

  modport source (output valid, command, slot, amount, input ready);
  modport sink   (input valid, command, slot, amount, output ready);
endinterface

interface fpha_out_if import fpha_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [SLOT_W-1:0] chosen_slot;
  logic [REM_W-1:0]  remaining;

  modport source (output valid, ok, chosen_slot, remaining, input ready);
  modport sink   (input valid, ok, chosen_slot, remaining, output ready);
endinterface

FILE: design/fit_policy_hole_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fit_policy_hole_allocator_unit
// Hole-size table with first/next/best/worst fit allocation.
// ----------------------------------------------------------------------------
// The hole table sits in one single-port-read, single-port-write memory with
// a registered read. An allocate word walks the whole table through the
// memory read port, one entry per cycle: the accept, a read of every entry,
// a wait for the last read data, and a write-back. One word is in flight at
// a time; the result sits in an output register and the next word is taken
// in the cycle after that result has been taken. Next fit starts its walk at
// the last granted index; best and worst fit break ties toward the lowest
// index. Entries must be written before they are read or scanned.
// ----------------------------------------------------------------------------
module fit_policy_hole_allocator_unit
  import fpha_pkg::*;
#(
  parameter int ENTRIES   = 128,
  parameter int SIZE_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  fpha_in_if.sink               in_chan,
  fpha_out_if.source            out_chan,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW    = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;

  // Control state
  state_t            state_r, state_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  policy_t           policy_r;
  logic [IDX_W-1:0]  nfp_r;
  logic              rd_vld_r;
  logic              found_r;
  logic              out_valid_r;

  // Payload registers
  logic [AMT_W-1:0]  amt_r;
  logic [IDX_W-1:0]  rd_idx_r;
  logic [SLOT_W-1:0] echo_r;
  logic [IDX_W-1:0]  best_idx_r;
  logic [CW-1:0]     best_left_r;
  logic              ok_r;
  logic [SLOT_W-1:0] cslot_r;
  logic [REM_W-1:0]  rem_r;

  // Memory
  logic [SIZE_BITS-1:0] mem [ENTRIES];
  logic [SIZE_BITS-1:0] mem_q;
  logic                 mem_re, mem_we;
  logic [IDX_W-1:0]     mem_raddr, mem_waddr;
  logic [SIZE_BITS-1:0] mem_wdata;

  // Misc comb
  logic                 accept;
  logic                 slot_ok;
  logic [IDX_W-1:0]     slot_idx;
  logic [SIZE_BITS-1:0] wr_val;
  logic [IDX_W-1:0]     scan_start;
  logic [IDX_W:0]       scan_sum;
  logic [IDX_W-1:0]     scan_addr;
  logic                 load_out;
  logic                 ok_nxt;
  logic [SLOT_W-1:0]    cslot_nxt;
  logic [REM_W-1:0]     rem_nxt;
  logic [CW-1:0]        hole, req, left;
  logic                 fits, take;
  logic                 cfg_wr;

  // ---------------------------------------------------------------- APB
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_POLICY);
  assign prdata = (paddr[2] == REG_POLICY) ? APB_DATA_W'(policy_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POL_FIRST;
    end else if (cfg_wr) begin
      policy_r <= policy_t'(pwdata[POLICY_W-1:0]);
    end
  end

  // ---------------------------------------------------------------- decode
  assign in_chan.ready = (state_r == ST_IDLE) && !out_valid_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign slot_ok       = 32'(in_chan.slot) < 32'(ENTRIES);
  assign slot_idx      = IDX_W'(in_chan.slot);
  assign wr_val        = SIZE_BITS'(in_chan.amount);

  // Scan address: start + count, wrapped into the table
  assign scan_start = (policy_r == POL_NEXT) ? nfp_r : '0;
  assign scan_sum   = {1'b0, scan_start} + {1'b0, cnt_r};
  assign scan_addr  = (scan_sum >= (IDX_W+1)'(ENTRIES))
                      ? IDX_W'(scan_sum - (IDX_W+1)'(ENTRIES))
                      : IDX_W'(scan_sum);

  // ---------------------------------------------------------------- FSM
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    mem_re    = 1'b0;
    mem_raddr = slot_idx;
    mem_we    = 1'b0;
    mem_waddr = slot_idx;
    mem_wdata = wr_val;
    load_out  = 1'b0;
    ok_nxt    = 1'b0;
    cslot_nxt = '0;
    rem_nxt   = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_t'(in_chan.command))
            CMD_WRITE: begin
              load_out  = 1'b1;
              cslot_nxt = in_chan.slot;
              if (slot_ok) begin
                mem_we  = 1'b1;
                ok_nxt  = 1'b1;
                rem_nxt = REM_W'(wr_val);
              end
            end
            CMD_READ: begin
              if (slot_ok) begin
                mem_re    = 1'b1;
                state_nxt = ST_RD;
              end else begin
                load_out  = 1'b1;
                cslot_nxt = in_chan.slot;
              end
            end
            CMD_ALLOC: begin
              cnt_nxt   = '0;
              state_nxt = ST_SCAN;
            end
            CMD_NOP: begin
              load_out = 1'b1;
            end
            default: begin
              load_out = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        mem_re    = 1'b1;
        mem_raddr = scan_addr;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == IDX_W'(ENTRIES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_LAST;
        end
      end
      ST_LAST: begin
        state_nxt = ST_WB;
      end
      ST_WB: begin
        load_out  = 1'b1;
        state_nxt = ST_IDLE;
        if (found_r) begin
          mem_we    = 1'b1;
          mem_waddr = best_idx_r;
          mem_wdata = SIZE_BITS'(best_left_r);
          ok_nxt    = 1'b1;
          cslot_nxt = SLOT_W'(best_idx_r);
          rem_nxt   = REM_W'(best_left_r);
        end
      end
      ST_RD: begin
        load_out  = 1'b1;
        ok_nxt    = 1'b1;
        cslot_nxt = echo_r;
        rem_nxt   = REM_W'(mem_q);
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_q <= mem[mem_raddr];
    end
  end

  // ---------------------------------------------------------------- scan
  // Evaluate the entry returned by the previous read
  assign hole = CW'(mem_q);
  assign req  = CW'(amt_r);
  assign fits = hole >= req;
  assign left = hole - req;
  assign take = rd_vld_r && fits &&
                (!found_r ||
                 (policy_r == POL_BEST  && left < best_left_r) ||
                 (policy_r == POL_WORST && left > best_left_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
      found_r  <= 1'b0;
      nfp_r    <= '0;
    end else begin
      rd_vld_r <= mem_re && (state_r == ST_SCAN);
      if (accept) begin
        found_r <= 1'b0;
      end else if (take) begin
        found_r <= 1'b1;
      end
      if (state_r == ST_WB && found_r && policy_r == POL_NEXT) begin
        nfp_r <= best_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      amt_r  <= in_chan.amount;
      echo_r <= in_chan.slot;
    end
    if (mem_re) begin
      rd_idx_r <= mem_raddr;
    end
    if (take) begin
      best_idx_r  <= rd_idx_r;
      best_left_r <= left;
    end
  end

  // ---------------------------------------------------------------- output
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      ok_r    <= ok_nxt;
      cslot_r <= cslot_nxt;
      rem_r   <= rem_nxt;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.ok          = ok_r;
  assign out_chan.chosen_slot = cslot_r;
  assign out_chan.remaining   = rem_r;

`ifndef SYNTHESIS
  // Write-back always produces a result word
  a_wb_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_WB |=> out_valid_r)
    else $error("write-back did not load a result");

  // Next-fit pointer stays inside the table
  a_nfp_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(nfp_r) < 32'(ENTRIES))
    else $error("next-fit pointer out of range");

  // Memory is written only on a write word or at write-back
  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE || state_r == ST_WB))
    else $error("memory write outside idle or write-back");

  // A scan data cycle is always the cycle after a scan read
  a_scan_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> $past(state_r) == ST_SCAN)
    else $error("scan data without scan read");

  // No new word while a result waits
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !accept)
    else $error("word taken while result pending");
`endif

endmodule
